[sv/rau_pkg.sv]
// ----------------------------------------------------------------------------
// rau_pkg
// Shared types and constants of the rational arithmetic unit.
// ----------------------------------------------------------------------------
package rau_pkg;

	localparam int WORD_BITS_DEF = 32;
	localparam int CMD_BITS      = 3;

	typedef enum logic [2:0] {
		CMD_NORM = 3'd0,
		CMD_ADD  = 3'd1,
		CMD_SUB  = 3'd2,
		CMD_MUL  = 3'd3,
		CMD_DIV  = 3'd4,
		CMD_EQ   = 3'd5,
		CMD_LT   = 3'd6,
		CMD_NONE = 3'd7
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_ZERO_DEN = 2'd1,
		ST_DIV_ZERO = 2'd2,
		ST_OVERFLOW = 2'd3
	} status_t;

	// datapath operations issued by the controller
	typedef enum logic [3:0] {
		OP_NOP     = 4'd0,
		OP_LOAD    = 4'd1,  // capture operands, load lhs into the reducer
		OP_GCD     = 4'd2,  // one remainder bit step
		OP_DIVN    = 4'd3,  // divide numerator by gcd, one bit a step
		OP_DIVD    = 4'd4,  // divide denominator by gcd
		OP_STORE_A = 4'd5,  // keep reduced lhs, load rhs
		OP_STORE_B = 4'd6,  // keep reduced rhs
		OP_MUL1    = 4'd7,  // first cross products
		OP_MUL2    = 4'd8,  // second cross products
		OP_COMB    = 4'd9,  // combine and load the result into the reducer
		OP_FINAL   = 4'd10, // check the reduced result and set the output
		OP_MUL3    = 4'd11  // product of the two denominators
	} op_t;

	typedef struct packed {
		op_t     op;
		logic    start_div;  // restart the bit counter of a division
		status_t err;        // status to post with OP_FINAL when not ok
		logic    err_valid;
	} rau_cmd_t;

	typedef struct packed {
		logic zero_lden;
		logic zero_rden;
		logic num_zero;     // value in the reducer is zero
		logic gcd_done;     // remainder operand reached zero
		logic div_done;     // bit counter exhausted
		logic ovf;          // reduced value does not fit
		logic bn_zero;
	} rau_stat_t;

endpackage

[sv/rational_arithmetic_unit.sv]
// ----------------------------------------------------------------------------
// rational_arithmetic_unit
// Reduced-fraction add, subtract, multiply, divide and compare.
// ----------------------------------------------------------------------------
// One transaction at a time. Each reduction runs a bit-serial Euclid GCD:
// a GCD takes as many remainders as Euclid needs (up to about 90 on 64-bit
// values), and two quotient divisions, of the numerator and then of the
// denominator by the GCD, follow. A binary command reduces up to three
// fractions, and an error ends a transaction early; all of these steps
// share one restoring divider. The result holds until it is taken.
module rational_arithmetic_unit #(
	parameter int WORD_BITS = rau_pkg::WORD_BITS_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [135:0] s_tdata,   // command[2:0], lhs_num, lhs_den, rhs_num, rhs_den
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [71:0]  m_tdata    // result_num[31:0], result_den[62:32], compare_true[63],
	                                // status[65:64]
);
	rau_pkg::rau_cmd_t  cmd;
	rau_pkg::rau_stat_t stat;
	logic busy, fire;
	logic [31:0] rnum;
	logic [30:0] rden;
	logic        rcmp;
	logic [1:0]  rst_s;

	assign s_tready = !busy;
	assign fire = s_tvalid && s_tready;
	assign m_tdata = {6'd0, rst_s, rcmp, rden, rnum};

	rau_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_fire(fire), .in_cmd(s_tdata[2:0]),
		.busy(busy), .out_valid(m_tvalid), .out_ready(m_tready),
		.cmd(cmd), .stat(stat)
	);

	rau_datapath #(.WORD_BITS(WORD_BITS)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .stat(stat),
		.in_cmd(s_tdata[2:0]), .in_ln(s_tdata[34:3]), .in_ld(s_tdata[66:35]),
		.in_rn(s_tdata[98:67]), .in_rd(s_tdata[130:99]),
		.res_num(rnum), .res_den(rden), .res_cmp(rcmp), .res_status(rst_s)
	);

endmodule

[sv/rau_datapath.sv]
// ----------------------------------------------------------------------------
// rau_datapath
// Operand registers, a bit-serial remainder unit for Euclid steps and
// quotients, a 33x33 signed multiplier and the result register.
// ----------------------------------------------------------------------------
module rau_datapath #(
	parameter int WORD_BITS = rau_pkg::WORD_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  rau_pkg::rau_cmd_t    cmd,
	output rau_pkg::rau_stat_t   stat,
	input  logic [2:0]           in_cmd,
	input  logic [31:0]          in_ln,
	input  logic [31:0]          in_ld,
	input  logic [31:0]          in_rn,
	input  logic [31:0]          in_rd,
	output logic [31:0]          res_num,
	output logic [30:0]          res_den,
	output logic                 res_cmp,
	output logic [1:0]           res_status
);
	localparam int W  = 2 * WORD_BITS;
	localparam int CW = $clog2(W + 1);

	logic [2:0]           op_q;
	logic [WORD_BITS-1:0] ln_q, ld_q, rn_q, rd_q;
	// reduced operands: signed numerator, positive denominator
	logic signed [WORD_BITS:0] an_q, bn_q;
	logic [WORD_BITS:0]        ad_q, bd_q;
	// reducer value
	logic          neg_q;
	logic [W-1:0]  un_q, ud_q;
	// gcd / remainder registers
	logic [W-1:0]  ga_q, gb_q, rem_q, quo_q, dvd_q;
	logic [CW-1:0] cnt_q;
	logic          phase_q;  // 0: gcd remainder, 1: quotient
	logic signed [W-1:0] p1_q, p2_q, p3_q;

	logic signed [W-1:0] lnx, ldx, rnx, rdx;
	assign lnx = W'($signed(ln_q));
	assign ldx = W'($signed(ld_q));
	assign rnx = W'($signed(rn_q));
	assign rdx = W'($signed(rd_q));

	function automatic logic [W-1:0] mag(input logic signed [W-1:0] v);
		mag = v[W-1] ? W'(-v) : W'(v);
	endfunction

	// one restoring division step on rem/quo using dividend dvd and divisor
	logic [W:0]   rshift;
	logic [W-1:0] divisor;
	logic         fits;
	always_comb begin
		divisor = phase_q ? ga_q : gb_q;
		rshift  = {rem_q, dvd_q[W-1]};
		fits    = rshift >= {1'b0, divisor};
	end

	logic signed [W-1:0] a_ext, b_ext, comb, dsign;
	always_comb begin
		a_ext = W'(an_q);
		b_ext = W'(bn_q);
		// denominator is p2 for mul/div, ad*bd in p3 for add/sub
		unique case (rau_pkg::cmd_t'(op_q))
			rau_pkg::CMD_ADD: begin
				comb  = p1_q + p2_q;
				dsign = p3_q;
			end
			rau_pkg::CMD_SUB: begin
				comb  = p1_q - p2_q;
				dsign = p3_q;
			end
			default: begin
				comb  = p1_q;
				dsign = p2_q;
			end
		endcase
	end

	logic [W-1:0] lim;
	assign lim = W'(1) << (WORD_BITS - 1);

	always_comb begin
		stat.zero_lden = (ld_q == '0);
		stat.zero_rden = (rd_q == '0);
		stat.num_zero  = (un_q == '0);
		stat.gcd_done  = (gb_q == '0);
		stat.div_done  = (cnt_q == '0);
		stat.ovf       = (ud_q > lim - W'(1)) ||
			(neg_q ? (un_q > lim) : (un_q > lim - W'(1)));
		stat.bn_zero   = (bn_q == '0);
	end

	logic is_mul;
	assign is_mul = (rau_pkg::cmd_t'(op_q) == rau_pkg::CMD_MUL);

	logic signed [W-1:0] ma, mb;
	always_comb begin
		if (cmd.op == rau_pkg::OP_MUL1) begin
			ma = a_ext;
			mb = is_mul ? b_ext : W'(bd_q);
		end else if (cmd.op == rau_pkg::OP_MUL2) begin
			ma = W'(ad_q);
			mb = is_mul ? W'(bd_q) : b_ext;
		end else begin
			ma = W'(ad_q);
			mb = W'(bd_q);
		end
	end
	logic signed [W-1:0] prod;
	assign prod = W'($signed(ma[WORD_BITS:0]) * $signed(mb[WORD_BITS:0]));

	always_ff @(posedge clk) begin
		unique case (cmd.op)
			rau_pkg::OP_LOAD: begin
				op_q <= in_cmd;
				ln_q <= in_ln[WORD_BITS-1:0];
				ld_q <= in_ld[WORD_BITS-1:0];
				rn_q <= in_rn[WORD_BITS-1:0];
				rd_q <= in_rd[WORD_BITS-1:0];
				neg_q <= in_ln[WORD_BITS-1] ^ in_ld[WORD_BITS-1];
				un_q <= mag(W'($signed(in_ln[WORD_BITS-1:0])));
				ud_q <= mag(W'($signed(in_ld[WORD_BITS-1:0])));
				ga_q <= mag(W'($signed(in_ln[WORD_BITS-1:0])));
				gb_q <= mag(W'($signed(in_ld[WORD_BITS-1:0])));
				phase_q <= 1'b0;
			end
			rau_pkg::OP_STORE_A: begin
				an_q <= neg_q ? -$signed((WORD_BITS+1)'(un_q)) : $signed((WORD_BITS+1)'(un_q));
				ad_q <= (WORD_BITS+1)'(ud_q);
				neg_q <= rn_q[WORD_BITS-1] ^ rd_q[WORD_BITS-1];
				un_q <= mag(rnx);
				ud_q <= mag(rdx);
				ga_q <= mag(rnx);
				gb_q <= mag(rdx);
				phase_q <= 1'b0;
			end
			rau_pkg::OP_STORE_B: begin
				bn_q <= neg_q ? -$signed((WORD_BITS+1)'(un_q)) : $signed((WORD_BITS+1)'(un_q));
				bd_q <= (WORD_BITS+1)'(ud_q);
			end
			rau_pkg::OP_MUL1: p1_q <= prod;
			rau_pkg::OP_MUL2: p2_q <= prod;
			rau_pkg::OP_MUL3: p3_q <= prod;
			rau_pkg::OP_COMB: begin
				neg_q <= comb[W-1] ^ dsign[W-1];
				un_q <= mag(comb);
				ud_q <= mag(dsign);
				ga_q <= mag(comb);
				gb_q <= mag(dsign);
				phase_q <= 1'b0;
			end
			rau_pkg::OP_GCD: begin
				if (cmd.start_div) begin
					rem_q <= '0;
					dvd_q <= ga_q;
					cnt_q <= CW'(W);
				end else begin
					rem_q <= fits ? W'(rshift - {1'b0, divisor}) : rshift[W-1:0];
					dvd_q <= dvd_q << 1;
					cnt_q <= cnt_q - CW'(1);
					if (cnt_q == CW'(1)) begin
						ga_q <= gb_q;
						gb_q <= fits ? W'(rshift - {1'b0, divisor}) : rshift[W-1:0];
					end
				end
			end
			rau_pkg::OP_DIVN, rau_pkg::OP_DIVD: begin
				if (cmd.start_div) begin
					rem_q <= '0;
					quo_q <= '0;
					dvd_q <= (cmd.op == rau_pkg::OP_DIVN) ? un_q : ud_q;
					cnt_q <= CW'(W);
					phase_q <= 1'b1;
				end else begin
					rem_q <= fits ? W'(rshift - {1'b0, divisor}) : rshift[W-1:0];
					quo_q <= {quo_q[W-2:0], fits};
					dvd_q <= dvd_q << 1;
					cnt_q <= cnt_q - CW'(1);
					if (cnt_q == CW'(1)) begin
						if (cmd.op == rau_pkg::OP_DIVN) un_q <= {quo_q[W-2:0], fits};
						else                            ud_q <= {quo_q[W-2:0], fits};
					end
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_num <= '0;
			res_den <= 31'd1;
			res_cmp <= 1'b0;
			res_status <= rau_pkg::ST_OK;
		end else if (cmd.op == rau_pkg::OP_FINAL) begin
			res_num <= '0;
			res_den <= 31'd1;
			res_cmp <= 1'b0;
			res_status <= rau_pkg::ST_OK;
			if (cmd.err_valid) begin
				res_status <= cmd.err;
			end else begin
				unique case (rau_pkg::cmd_t'(op_q))
					rau_pkg::CMD_EQ: res_cmp <= (p1_q == p2_q);
					rau_pkg::CMD_LT: res_cmp <= (p1_q < p2_q);
					rau_pkg::CMD_NONE: ;
					// the reducer already holds the rhs, take the stored lhs
					rau_pkg::CMD_NORM: begin
						if (an_q != '0) begin
							res_num <= 32'(an_q);
							res_den <= 31'(ad_q);
						end
					end
					default: begin
						if (un_q != '0) begin
							if (stat.ovf) begin
								res_status <= rau_pkg::ST_OVERFLOW;
							end else begin
								res_num <= 32'(neg_q ? -$signed(W'(un_q)) : $signed(W'(un_q)));
								res_den <= 31'(ud_q);
							end
						end
					end
				endcase
			end
		end
	end

endmodule

[sv/rau_ctrl.sv]
// ----------------------------------------------------------------------------
// rau_ctrl
// Sequencer: reduces each operand, forms the products and, for arithmetic commands, reduces the result.
// ----------------------------------------------------------------------------
module rau_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_fire,
	input  logic [2:0]         in_cmd,
	output logic               busy,
	output logic               out_valid,
	input  logic               out_ready,
	output rau_pkg::rau_cmd_t  cmd,
	input  rau_pkg::rau_stat_t stat
);
	typedef enum logic [9:0] {
		S_IDLE  = 10'b0000000001,
		S_CHECK = 10'b0000000010,
		S_RED   = 10'b0000000100,
		S_GCD   = 10'b0000001000,
		S_DIVN  = 10'b0000010000,
		S_DIVD  = 10'b0000100000,
		S_NEXT  = 10'b0001000000,
		S_MUL   = 10'b0010000000,
		S_FIN   = 10'b0100000000,
		S_OUT   = 10'b1000000000
	} state_t;

	state_t     state_q;
	logic [2:0] c_q;
	logic [1:0] which_q;  // 0 lhs, 1 rhs, 2 result
	logic       start_q;
	logic [1:0] mstep_q;
	logic       err_q;
	rau_pkg::status_t errc_q;

	logic binary;
	assign binary = (c_q != 3'(rau_pkg::CMD_NORM)) && (c_q != 3'(rau_pkg::CMD_NONE));
	assign busy = (state_q != S_IDLE);
	assign out_valid = (state_q == S_OUT);

	always_comb begin
		cmd = '0;
		cmd.op = rau_pkg::OP_NOP;
		cmd.start_div = start_q;
		cmd.err = errc_q;
		cmd.err_valid = err_q;
		unique case (state_q)
			S_IDLE: if (in_fire) cmd.op = rau_pkg::OP_LOAD;
			S_GCD:  cmd.op = rau_pkg::OP_GCD;
			S_DIVN: cmd.op = rau_pkg::OP_DIVN;
			S_DIVD: cmd.op = rau_pkg::OP_DIVD;
			S_NEXT: cmd.op = (which_q == 2'd0) ? rau_pkg::OP_STORE_A : rau_pkg::OP_STORE_B;
			S_MUL: begin
				unique case (mstep_q)
					2'd0:    cmd.op = rau_pkg::OP_MUL1;
					2'd1:    cmd.op = rau_pkg::OP_MUL2;
					2'd2:    cmd.op = rau_pkg::OP_MUL3;
					default: cmd.op = rau_pkg::OP_COMB;
				endcase
			end
			S_FIN:  cmd.op = rau_pkg::OP_FINAL;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			c_q <= '0;
			which_q <= '0;
			start_q <= 1'b0;
			mstep_q <= '0;
			err_q <= 1'b0;
			errc_q <= rau_pkg::ST_OK;
		end else begin
			unique case (state_q)
				S_IDLE: if (in_fire) begin
					c_q <= in_cmd;
					which_q <= 2'd0;
					err_q <= 1'b0;
					errc_q <= rau_pkg::ST_OK;
					state_q <= S_CHECK;
				end
				S_CHECK: begin
					if (c_q == 3'(rau_pkg::CMD_NONE)) begin
						state_q <= S_FIN;
					end else if (stat.zero_lden || (binary && stat.zero_rden)) begin
						err_q <= 1'b1;
						errc_q <= rau_pkg::ST_ZERO_DEN;
						state_q <= S_FIN;
					end else begin
						state_q <= S_RED;
					end
				end
				S_RED: begin
					// a zero numerator skips the gcd; a zero result is output as 0/1
					start_q <= 1'b1;
					state_q <= stat.num_zero ? S_NEXT : S_GCD;
				end
				S_GCD: begin
					if (start_q) start_q <= 1'b0;
					else if (stat.div_done) begin
						if (stat.gcd_done) begin
							start_q <= 1'b1;
							state_q <= S_DIVN;
						end else start_q <= 1'b1;
					end
				end
				S_DIVN: begin
					if (start_q) start_q <= 1'b0;
					else if (stat.div_done) begin
						start_q <= 1'b1;
						state_q <= S_DIVD;
					end
				end
				S_DIVD: begin
					if (start_q) start_q <= 1'b0;
					else if (stat.div_done) state_q <= S_NEXT;
				end
				S_NEXT: begin
					start_q <= 1'b0;
					if (stat.num_zero) begin
						// datapath value is 0 / anything: the final step outputs it as 0/1
					end
					if (which_q == 2'd2) begin
						state_q <= S_FIN;
					end else if (stat.ovf && !stat.num_zero) begin
						err_q <= 1'b1;
						errc_q <= rau_pkg::ST_OVERFLOW;
						state_q <= S_FIN;
					end else if (which_q == 2'd0 && binary) begin
						which_q <= 2'd1;
						state_q <= S_RED;
					end else if (!binary) begin
						which_q <= 2'd2;
						state_q <= S_FIN;
					end else begin
						mstep_q <= 2'd0;
						state_q <= S_MUL;
					end
				end
				S_MUL: begin
					if (mstep_q == 2'd0 && c_q == 3'(rau_pkg::CMD_DIV) && stat.bn_zero) begin
						err_q <= 1'b1;
						errc_q <= rau_pkg::ST_DIV_ZERO;
						state_q <= S_FIN;
					end else if (mstep_q == 2'd3) begin
						which_q <= 2'd2;
						state_q <= S_RED;
					end else if (mstep_q == 2'd1 &&
						(c_q == 3'(rau_pkg::CMD_EQ) || c_q == 3'(rau_pkg::CMD_LT))) begin
						state_q <= S_FIN;
					end
					mstep_q <= mstep_q + 2'd1;
				end
				S_FIN: state_q <= S_OUT;
				S_OUT: if (out_ready) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

[tb/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Checks the rational arithmetic unit against a fraction predictor.
// ----------------------------------------------------------------------------
// Directed operands (extremes, zero denominators, overflow, every command)
// are followed by random bursts of small and full-width fractions. Each
// result is compared field by field with the oldest predicted fraction.
// ----------------------------------------------------------------------------
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int W = 32;
	localparam longint LIM = 64'sd1 << (W - 1);
	localparam int MAX_CYCLES = 100000000;

	// packed from the top bit down, matching m_tdata[65:0]
	typedef struct packed {
		rau_pkg::status_t st;
		logic             cmp;
		logic [30:0]      den;
		logic [31:0]      num;
	} frac_res_t;

	logic         clk = 0;
	logic         arst_n = 0;
	logic         s_tvalid = 0;
	logic         s_tready;
	logic [135:0] s_tdata = '0;
	logic         m_tvalid;
	logic         m_tready = 0;
	logic [71:0]  m_tdata;

	frac_res_t fraction_q[$];
	int        fail_cnt = 0;
	int        cycle_cnt = 0;
	int        gap_len = 0;

	rational_arithmetic_unit #(.WORD_BITS(W)) dut (.*);

	always begin
		#1 clk = 1;
		#1 clk = 0;
	end

	function automatic longint unsigned gcd64(longint unsigned a, longint unsigned b);
		longint unsigned t;
		while (b != 0) begin
			t = a % b;
			a = b;
			b = t;
		end
		return a;
	endfunction

	function automatic longint unsigned mag(longint v);
		return v < 0 ? 64'd0 - longint'(v) : v;
	endfunction

	// reduce n/d (d nonzero); returns ok or overflow
	function automatic rau_pkg::status_t reduce_frac(longint n, longint d, output longint rn,
			output longint rd);
		longint unsigned un, ud, g;
		bit neg;
		rn = 0;
		rd = 1;
		if (n == 0) return rau_pkg::ST_OK;
		neg = (n < 0) != (d < 0);
		un = mag(n);
		ud = mag(d);
		g = gcd64(un, ud);
		un /= g;
		ud /= g;
		if (ud > LIM - 1) return rau_pkg::ST_OVERFLOW;
		if (neg ? (un > LIM) : (un > LIM - 1)) return rau_pkg::ST_OVERFLOW;
		rn = neg ? -longint'(un) : longint'(un);
		rd = ud;
		return rau_pkg::ST_OK;
	endfunction

	function automatic frac_res_t predict_fraction(rau_pkg::cmd_t cmd,
			logic signed [31:0] ln_w, logic signed [31:0] ld_w,
			logic signed [31:0] rn_w, logic signed [31:0] rd_w);
		longint ln, ld, rn, rd, an, ad, bn, bd, cn, cd;
		rau_pkg::status_t st;
		bit cmp;
		bit binary;
		frac_res_t r;
		ln = ln_w; ld = ld_w; rn = rn_w; rd = rd_w;
		an = 0; ad = 1; bn = 0; bd = 1; cn = 0; cd = 1;
		st = rau_pkg::ST_OK;
		cmp = 0;
		binary = cmd != rau_pkg::CMD_NORM && cmd != rau_pkg::CMD_NONE;
		if (cmd == rau_pkg::CMD_NONE) st = rau_pkg::ST_OK;
		else if (ld == 0 || (binary && rd == 0)) st = rau_pkg::ST_ZERO_DEN;
		else begin
			st = reduce_frac(ln, ld, an, ad);
			if (st == rau_pkg::ST_OK && binary) st = reduce_frac(rn, rd, bn, bd);
			if (st == rau_pkg::ST_OK) begin
				case (cmd)
					rau_pkg::CMD_NORM: begin cn = an; cd = ad; end
					rau_pkg::CMD_ADD: st = reduce_frac(an * bd + bn * ad, ad * bd, cn, cd);
					rau_pkg::CMD_SUB: st = reduce_frac(an * bd - bn * ad, ad * bd, cn, cd);
					rau_pkg::CMD_MUL: st = reduce_frac(an * bn, ad * bd, cn, cd);
					rau_pkg::CMD_DIV: begin
						if (bn == 0) st = rau_pkg::ST_DIV_ZERO;
						else st = reduce_frac(an * bd, ad * bn, cn, cd);
					end
					rau_pkg::CMD_EQ: cmp = (an * bd) == (bn * ad);
					default: cmp = (an * bd) < (bn * ad);
				endcase
			end
		end
		if (st != rau_pkg::ST_OK) begin
			cn = 0; cd = 1; cmp = 0;
		end
		r.num = cn[31:0];
		r.den = cd[30:0];
		r.cmp = cmp;
		r.st = st;
		return r;
	endfunction

	// hold valid within a burst, insert a random gap (possibly none) between bursts
	task automatic send_fraction(rau_pkg::cmd_t cmd, logic [31:0] ln, logic [31:0] ld,
			logic [31:0] rn, logic [31:0] rd);
		int g;
		if (gap_len == 0) begin
			gap_len = $urandom_range(1, 12);
			g = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (g > 0) begin
				s_tvalid <= 0;
				repeat (g) @(posedge clk);
			end
		end
		gap_len--;
		s_tvalid <= 1;
		s_tdata <= {5'd0, rd, rn, ld, ln, cmd};
		fraction_q.push_back(predict_fraction(cmd, ln, ld, rn, rd));
		@(posedge clk);
		while (!s_tready) @(posedge clk);
	endtask

	task automatic stop_sending();
		s_tvalid <= 0;
		gap_len = 0;
	endtask

	// receiver stall pattern and result checking
	always @(posedge clk) begin
		frac_res_t got, exp_r;
		cycle_cnt <= cycle_cnt + 1;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				got = m_tdata[65:0];
				if (fraction_q.size() == 0) begin
					$display("%0t: unexpected result %h", $time, got);
					fail_cnt++;
				end else begin
					exp_r = fraction_q.pop_front();
					if (got.num !== exp_r.num || got.den !== exp_r.den
							|| got.cmp !== exp_r.cmp || got.st !== exp_r.st) begin
						$display("%0t: mismatch exp num %h den %h cmp %b st %0d",
							$time, exp_r.num, exp_r.den, exp_r.cmp, exp_r.st);
						$display("%0t:          got num %h den %h cmp %b st %0d",
							$time, got.num, got.den, got.cmp, got.st);
						fail_cnt++;
					end
				end
			end
			m_tready <= ((cycle_cnt / 64) % 4 == 3) ? 1'b1 : ($urandom_range(0, 2) != 0);
		end
	end

	always @(posedge clk) begin
		if (cycle_cnt >= MAX_CYCLES) begin
			$display("tb_top: FAIL");
			$finish;
		end
	end

	function automatic logic [31:0] rand_word(int mode);
		case (mode)
			0: return $urandom;
			1: return $urandom_range(0, 40) - 20;
			2: return $urandom_range(0, 2000) - 1000;
			default: return $urandom & (32'hFFFF_FFFF >> $urandom_range(0, 31));
		endcase
	endfunction

	task automatic test_directed();
		localparam logic [31:0] MN = 32'h8000_0000, MX = 32'h7FFF_FFFF, M1 = 32'hFFFF_FFFF;
		send_fraction(rau_pkg::CMD_NORM, 6, -4, 0, 0);
		send_fraction(rau_pkg::CMD_NORM, 0, -7, 1, 1);
		send_fraction(rau_pkg::CMD_NORM, 5, 0, 1, 1);
		send_fraction(rau_pkg::CMD_ADD, 1, 2, 1, 0);
		send_fraction(rau_pkg::CMD_NORM, MN, M1, 0, 1);
		send_fraction(rau_pkg::CMD_NORM, 1, MN, 0, 1);
		send_fraction(rau_pkg::CMD_NORM, MN, MN, 0, 1);
		send_fraction(rau_pkg::CMD_NORM, MX, MN, 0, 1);
		send_fraction(rau_pkg::CMD_ADD, 1, 2, 1, 3);
		send_fraction(rau_pkg::CMD_ADD, MX, 1, MX, 1);
		send_fraction(rau_pkg::CMD_SUB, MN, 1, 1, 1);
		send_fraction(rau_pkg::CMD_SUB, 3, 4, 3, 4);
		send_fraction(rau_pkg::CMD_MUL, MX, 2, MX, 3);
		send_fraction(rau_pkg::CMD_MUL, MN, 1, -1, 1);
		send_fraction(rau_pkg::CMD_DIV, 1, 2, 0, 5);
		send_fraction(rau_pkg::CMD_DIV, 1, MX, MX, 1);
		send_fraction(rau_pkg::CMD_DIV, 2, 3, -4, 9);
		send_fraction(rau_pkg::CMD_EQ, 2, 4, -1, -2);
		send_fraction(rau_pkg::CMD_EQ, 1, 3, 1, 2);
		send_fraction(rau_pkg::CMD_LT, -1, 2, 1, 3);
		send_fraction(rau_pkg::CMD_LT, MX, 1, MN, 1);
		send_fraction(rau_pkg::CMD_NONE, 5, 0, 3, 0);
		send_fraction(rau_pkg::CMD_NONE, MN, MX, M1, MN);
		stop_sending();
	endtask

	task automatic test_random(int count);
		rau_pkg::cmd_t cmd;
		int mode;
		repeat (count) begin
			cmd = rau_pkg::cmd_t'($urandom_range(0, 7));
			mode = ($urandom_range(0, 9) < 7) ? $urandom_range(1, 3) : 0;
			send_fraction(cmd, rand_word(mode),
				($urandom_range(0, 40) == 0) ? 32'd0 : rand_word(mode),
				($urandom_range(0, 30) == 0) ? 32'd0 : rand_word(mode),
				($urandom_range(0, 40) == 0) ? 32'd0 : rand_word(mode));
		end
		stop_sending();
	endtask

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		test_directed();
		test_random(1830);
		while (fraction_q.size() != 0) @(posedge clk);
		repeat (50) @(posedge clk);
		if (fail_cnt == 0) $display("tb_top: PASS");
		else $display("tb_top: FAIL");
		$finish;
	end

endmodule
